// ===== src/rso_pkg.sv =====
// shared types and constants for the rectangle sweep overlap block
package rso_pkg;

  localparam int COORD_W = 32;
  localparam int ID_W    = 32;
  localparam int CNT_W   = 6;
  localparam int KEY_W   = 4 * COORD_W + ID_W;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_LIMIT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] y_high;
    logic [ID_W-1:0]           rect_id;
    logic [CNT_W-1:0]          hit_limit;
  } rect_t;

  typedef struct packed {
    logic [ID_W-1:0]  hit_id;
    logic [1:0]       status;
    logic [CNT_W-1:0] hit_count;
    logic [31:0]      accepted_count;
    logic             last;
  } result_t;

  // sort key: sign bits flipped so that an unsigned compare orders signed fields
  function automatic logic [KEY_W-1:0] make_key(rect_t r);
    logic [COORD_W-1:0] m;
    m = {1'b1, {(COORD_W-1){1'b0}}};
    return {r.x_low ^ m, r.x_high ^ m, r.y_low ^ m, r.y_high ^ m, r.rect_id};
  endfunction

  // recover a signed coordinate from a key field
  function automatic logic signed [COORD_W-1:0] key_coord(logic [COORD_W-1:0] f);
    return $signed(f ^ {1'b1, {(COORD_W-1){1'b0}}});
  endfunction

endpackage

// ===== src/rectangle_sweep_overlap.sv =====
// Sweep-line rectangle overlap: per request, one scan pass over the slot ram
// drops expired entries and marks overlaps, then each emitted id takes one
// selection pass through the slot ram plus a next and an emit state.
// One request is handled at a time. Out-of-order requests skip the scan and
// go straight to the finish state.
// Synchronous reset empties the table and clears the bottom edge and count.
module rectangle_sweep_overlap #(
  parameter int ACTIVE_MAX = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rect_valid,
  output logic             rect_stall,
  input  rso_pkg::rect_t   rect,
  output logic             result_valid,
  input  logic             result_stall,
  output rso_pkg::result_t result
);

  localparam int IW = $clog2(ACTIVE_MAX);
  localparam int CW = $clog2(ACTIVE_MAX + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(ACTIVE_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_NEXT = 3'd2;
  localparam logic [2:0] S_SEL  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                  state;
  rso_pkg::rect_t              cur;
  logic [rso_pkg::KEY_W-1:0]   cur_key;
  logic [ACTIVE_MAX-1:0]       valid;
  logic [ACTIVE_MAX-1:0]       hit;
  logic [CW-1:0]               cnt;
  logic [rso_pkg::CNT_W-1:0]   nh;
  logic [rso_pkg::CNT_W-1:0]   k;
  logic [1:0]                  st;
  logic                        dup;
  logic                        free_found;
  logic [IW-1:0]               free_slot;
  logic [rso_pkg::KEY_W-1:0]   prev_key;
  logic [rso_pkg::KEY_W-1:0]   best_key;
  logic                        best_found;
  logic [31:0]                 taken;
  logic signed [31:0]          last_bottom;

  logic                        ram_we;
  logic [IW-1:0]               ram_raddr;
  logic [rso_pkg::KEY_W-1:0]   ram_rdata;
  logic [IW-1:0]               pidx;
  logic                        proc_en;
  logic                        out_free;
  logic                        res_load;
  logic                        live;
  logic                        expired;
  logic                        overlap;
  logic                        better;

  rso_ram #(.WIDTH(rso_pkg::KEY_W), .DEPTH(ACTIVE_MAX)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (cur_key),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan addressing: address cnt is issued, entry cnt-1 is processed
  assign ram_raddr = (cnt < LAST_CNT) ? cnt[IW-1:0] : '0;
  assign pidx      = IW'(cnt - CW'(1));
  assign proc_en   = (cnt != '0);
  assign out_free  = !result_valid || !result_stall;
  assign res_load  = ((state == S_EMIT) || (state == S_FIN)) && out_free;
  assign rect_stall = (state != S_IDLE);

  // per-entry compares on the data read from the slot ram
  always_comb begin
    expired = valid[pidx] &&
              (rso_pkg::key_coord(ram_rdata[63:32]) < cur.y_low);
    live    = valid[pidx] && !expired;
    overlap = (cur.x_low <= rso_pkg::key_coord(ram_rdata[127:96])) &&
              (rso_pkg::key_coord(ram_rdata[159:128]) <= cur.x_high) &&
              (cur.y_low <= rso_pkg::key_coord(ram_rdata[63:32])) &&
              (rso_pkg::key_coord(ram_rdata[95:64]) <= cur.y_high);
    better  = hit[pidx] && ((k == '0) || (ram_rdata > prev_key)) &&
              (!best_found || (ram_rdata < best_key));
  end

  assign ram_we = (state == S_FIN) && out_free && (st == rso_pkg::ST_OK) &&
                  !dup && free_found;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      taken        <= '0;
      last_bottom  <= '0;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      // result register: loaded by emit or finish, cleared once taken
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (rect_valid) begin
            cur     <= rect;
            cur_key <= rso_pkg::make_key(rect);
            k       <= '0;
            nh      <= '0;
            dup     <= 1'b0;
            free_found <= 1'b0;
            free_slot  <= '0;
            hit     <= '0;
            cnt     <= '0;
            if (taken != '0 && rect.y_low < last_bottom) begin
              st    <= rso_pkg::ST_ORDER;
              state <= S_FIN;
            end else begin
              st          <= rso_pkg::ST_OK;
              last_bottom <= rect.y_low;
              if (taken != '1) begin
                taken <= taken + 32'd1;
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + CW'(1);
          if (proc_en) begin
            if (expired) begin
              valid[pidx] <= 1'b0;
            end
            if (!live && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= pidx;
            end
            if (live && ram_rdata == cur_key) begin
              dup <= 1'b1;
            end
            if (live && overlap) begin
              hit[pidx] <= 1'b1;
              nh        <= nh + rso_pkg::CNT_W'(1);
            end
            if (cnt == LAST_CNT) begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          cnt        <= '0;
          best_found <= 1'b0;
          if (k == nh) begin
            state <= S_FIN;
          end else if (k == cur.hit_limit) begin
            st    <= rso_pkg::ST_LIMIT;
            state <= S_FIN;
          end else begin
            state <= S_SEL;
          end
        end
        S_SEL: begin
          cnt <= cnt + CW'(1);
          if (proc_en) begin
            if (better) begin
              best_key   <= ram_rdata;
              best_found <= 1'b1;
            end
            if (cnt == LAST_CNT) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result       <= '{hit_id: best_key[31:0], status: rso_pkg::ST_OK,
                              hit_count: '0, accepted_count: '0, last: 1'b0};
            prev_key     <= best_key;
            k            <= k + rso_pkg::CNT_W'(1);
            state        <= S_NEXT;
          end
        end
        S_FIN: begin
          if (out_free) begin
            result       <= '{hit_id: '0,
                              status: (st == rso_pkg::ST_OK && !dup && !free_found) ?
                                      rso_pkg::ST_FULL : st,
                              hit_count: k, accepted_count: taken, last: 1'b1};
            if (ram_we) begin
              valid[free_slot] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/rso_ram.sv =====
// generic single write port ram with registered read
module rso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rso_checker.sv =====
// port-level checks for the rectangle sweep overlap block, with bind
module rso_checker (
  input logic             clk,
  input logic             rst,
  input logic             rect_valid,
  input logic             rect_stall,
  input rso_pkg::rect_t   rect,
  input logic             result_valid,
  input logic             result_stall,
  input rso_pkg::result_t result
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    rect_valid && rect_stall |=> rect_valid && $stable(rect))
    else $error("stalled request changed");

  // non-final results carry only an id
  a_plain: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |->
      result.status == rso_pkg::ST_OK && result.hit_count == '0 &&
      result.accepted_count == '0)
    else $error("non-final result carries status fields");

  // an out-of-order request reports no hits
  a_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last && result.status == rso_pkg::ST_ORDER |->
      result.hit_count == '0 && result.hit_id == '0)
    else $error("out-of-order result with hits");

  // a request is taken only after the previous one is finished
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rect_valid && !rect_stall |=> rect_stall)
    else $error("request taken while busy");

endmodule

bind rectangle_sweep_overlap rso_checker u_rso_checker (
  .clk          (clk),
  .rst          (rst),
  .rect_valid   (rect_valid),
  .rect_stall   (rect_stall),
  .rect         (rect),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
